### sv/mtflru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtflru_pkg;

   // Sequencer states: idle, register key compares, move and respond
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MATCH = 2'd1,
      ST_MOVE  = 2'd2
   } state_type;

   // Command codes on req_command
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic ready;   // sequencer free to take a word
      logic take;    // word accepted this cycle
      logic match;   // cells register their key compare
      logic move;    // cells shift, result is loaded
   } ctrl_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] value;
   } entry_type;

endpackage

`default_nettype wire

### sv/mtflru_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mtflru_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   match_en,
   input  wire                   move_en,
   input  wire                   insert,
   input  wire                   hit_all,
   input  wire                   valid,
   input  wire  [31:0]           cmp_key,
   input  mtflru_pkg::entry_type prev_entry,
   input  wire                   hit_above_in,
   input  wire  [31:0]           val_or_in,
   output mtflru_pkg::entry_type entry,
   output logic                  hit_above_out,
   output logic [31:0]           val_or_out
);
   import mtflru_pkg::*;

   entry_type entry_ff;
   logic      match_ff;
   logic      first;
   logic      shift;

   // frontmost match: this cell matched and nothing in front did
   assign first         = match_ff & ~hit_above_in;
   assign hit_above_out = hit_above_in | match_ff;
   assign val_or_out    = val_or_in | (first ? entry_ff.value : 32'd0);

   // insert shifts the whole row; a hit shifts the front up to the found cell
   assign shift = move_en & (insert | (hit_all & ~hit_above_in));
   assign entry = entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else if (match_en) begin
         match_ff <= valid & (entry_ff.key == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= prev_entry;
      end
   end

endmodule

`default_nettype wire

### sv/mtflru_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mtflru_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  rsp_stall,
   output mtflru_pkg::ctrl_type ctrl
);
   import mtflru_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.ready = 1'b1;
            ctrl.take  = req_valid;
         end
         ST_MATCH: begin
            ctrl.match = 1'b1;
         end
         ST_MOVE: begin
            ctrl.move = ~rsp_stall;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### sv/move_to_front_lru_list.sv
// Move-to-front LRU list of DEPTH key/value entries, front = most recent.
// Input channel req_*: one word per item, req_command selects insert (new
// entry at the front, duplicates allowed, tail dropped when full) or search
// (frontmost matching key moves to the front, its value is returned).
// Result channel rsp_*: exactly one word per item, carrying hit, the found
// value, the eviction flag and the occupancy after the item.
// After acceptance an item first registers the key compares in every cell,
// then shifts the row and loads the result.
// The sequencer walks the accept, compare and move steps, so a new item is
// taken only after the last one has moved; the compare is registered so the
// priority pick and row shift get a step of their own.
// The result sits in an output register, so the next word is taken while a
// result waits; a stalled receiver holds the block in its move step until
// the previous result has left, and meanwhile req_ready stays low.
// Reset (synchronous, active high) empties the list at once; the entry
// storage itself is not cleared, only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_lru_list #(
   parameter int DEPTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_command,
   input  wire  [31:0] req_key,
   input  wire  [31:0] req_value,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_found_value,
   output logic        rsp_evicted,
   output logic [4:0]  rsp_occupancy
);
   import mtflru_pkg::*;

   // count has to hold DEPTH itself
   localparam int CW = $clog2(DEPTH + 1);

   ctrl_type ctrl;
   logic     rsp_stall;

   // captured input word
   logic        cmd_ff;
   logic [31:0] key_ff;
   logic [31:0] value_ff;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   logic        rsp_valid_ff;
   logic        hit_ff;
   logic [31:0] found_ff;
   logic        evicted_ff;
   logic [4:0]  occ_ff;

   // chain wires between cells: index i feeds cell i
   entry_type   entries [DEPTH];
   entry_type   prev    [DEPTH];
   logic        hit_chain [DEPTH+1];
   logic [31:0] val_chain [DEPTH+1];

   logic        insert;
   logic        hit_all;
   logic [31:0] found_value;
   logic        full;
   logic [CW+4:0] occ_wide;

   assign rsp_stall = rsp_valid_ff & ~rsp_ready;

   mtflru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   assign req_ready = ctrl.ready;

   assign insert      = (cmd_ff == CMD_INSERT);
   assign hit_all     = hit_chain[DEPTH];
   assign found_value = val_chain[DEPTH];
   assign full        = (count_ff == CW'(DEPTH));

   assign hit_chain[0] = 1'b0;
   assign val_chain[0] = 32'd0;

   // new front entry: the inserted word, or the found entry on a hit
   assign prev[0].key   = key_ff;
   assign prev[0].value = insert ? value_ff : found_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i > 0) begin : g_link
         assign prev[i] = entries[i-1];
      end

      mtflru_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .match_en      (ctrl.match),
         .move_en       (ctrl.move),
         .insert        (insert),
         .hit_all       (hit_all),
         .valid         (CW'(i) < count_ff),
         .cmp_key       (key_ff),
         .prev_entry    (prev[i]),
         .hit_above_in  (hit_chain[i]),
         .val_or_in     (val_chain[i]),
         .entry         (entries[i]),
         .hit_above_out (hit_chain[i+1]),
         .val_or_out    (val_chain[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         cmd_ff   <= req_command;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // occupancy grows on insert until full, then the tail is dropped
   always_comb begin
      count_in = count_ff;
      if (insert && !full) begin
         count_in = count_ff + CW'(1);
      end
   end

   assign occ_wide = {5'd0, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.move) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.move) begin
         hit_ff     <= ~insert & hit_all;
         found_ff   <= insert ? 32'd0 : found_value;
         evicted_ff <= insert & full;
         occ_ff     <= occ_wide[4:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_found_value = found_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_occupancy   = occ_ff;

endmodule

`default_nettype wire
